// File: rtl/awm_pkg.sv
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types and constants of the sliding-window anagram matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int SYM_W       = 8;
    localparam int SYM_COUNT   = 1 << SYM_W;
    localparam int BAL_W       = 8;
    localparam int MM_W        = 9;
    localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int SLOT_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W       = 32;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic {
        ST_TAKE,
        ST_LEAVE
    } seq_state_t;

    // One balance operation: clear the table, or add +1 / -1 to one entry.
    typedef struct packed {
        logic             valid;
        logic             clear;
        logic             inc;
        logic             check;
        logic [SYM_W-1:0] addr;
        logic [POS_W-1:0] start_index;
    } bal_op_t;

    // Outcome of an operation that carries a window check.
    typedef struct packed {
        logic             check_done;
        logic             hit;
        logic [POS_W-1:0] start_index;
    } bal_res_t;

endpackage

// File: rtl/awm_balance_ram.sv
// ----------------------------------------------------------------------------
// awm_balance_ram
// Symbol balance memory with a two-stage read-modify-write and the mismatch
// counter.
// ----------------------------------------------------------------------------
module awm_balance_ram (
    input  logic              aclk,
    input  logic              aresetn,
    input  awm_pkg::bal_op_t  op_i,
    output awm_pkg::bal_res_t res_o
);
    import awm_pkg::*;

    logic signed [BAL_W-1:0] mem [SYM_COUNT];
    logic signed [BAL_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic [SYM_COUNT-1:0]    valid_reg;
    bal_op_t                 op_reg;
    logic                    last_wr_reg;
    logic                    last_clr_reg;
    logic [SYM_W-1:0]        last_addr_reg;
    logic signed [BAL_W-1:0] last_data_reg;
    logic [MM_W-1:0]         mm_reg;

    logic signed [BAL_W-1:0] before_val;
    logic signed [BAL_W-1:0] after_val;
    logic [MM_W-1:0]         mm_next;
    logic                    do_write;

    // Stage one: read data and the entry's valid bit.
    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[op_i.addr];
        rd_valid_reg <= valid_reg[op_i.addr];
        if (do_write) begin
            mem[op_reg.addr] <= after_val;
        end
    end

    // Stage two: the value seen is the newest one, taking the write or clear
    // of the previous cycle into account.
    always_comb begin
        if (last_wr_reg && (last_addr_reg == op_reg.addr)) begin
            before_val = last_data_reg;
        end else if (last_clr_reg || !rd_valid_reg) begin
            before_val = '0;
        end else begin
            before_val = rd_data_reg;
        end
        after_val = op_reg.inc ? (before_val + BAL_W'(1)) : (before_val - BAL_W'(1));
        do_write  = op_reg.valid && !op_reg.clear;
        mm_next   = mm_reg;
        if (op_reg.valid) begin
            if (op_reg.clear) begin
                mm_next = '0;
            end else begin
                mm_next = mm_reg + MM_W'(before_val == '0) - MM_W'(after_val == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg.valid <= 1'b0;
            valid_reg    <= '0;
            last_wr_reg  <= 1'b0;
            last_clr_reg <= 1'b0;
            mm_reg       <= '0;
        end else begin
            op_reg.valid <= op_i.valid;
            if (op_reg.valid && op_reg.clear) begin
                valid_reg <= '0;
            end else if (do_write) begin
                valid_reg[op_reg.addr] <= 1'b1;
            end
            last_wr_reg  <= do_write;
            last_clr_reg <= op_reg.valid && op_reg.clear;
            mm_reg       <= mm_next;
        end
        op_reg.clear       <= op_i.clear;
        op_reg.inc         <= op_i.inc;
        op_reg.check       <= op_i.check;
        op_reg.addr        <= op_i.addr;
        op_reg.start_index <= op_i.start_index;
        last_addr_reg      <= op_reg.addr;
        last_data_reg      <= after_val;
    end

    assign res_o.check_done  = op_reg.valid && !op_reg.clear && op_reg.check;
    assign res_o.hit         = res_o.check_done && (mm_next == '0);
    assign res_o.start_index = op_reg.start_index;

endmodule

// File: rtl/awm_ring_ram.sv
// ----------------------------------------------------------------------------
// awm_ring_ram
// Ring of the most recent text symbols, one read and one write port.
// ----------------------------------------------------------------------------
module awm_ring_ram (
    input  logic                       aclk,
    input  logic [awm_pkg::SLOT_W-1:0] rd_addr,
    output logic [awm_pkg::SYM_W-1:0]  rd_data,
    input  logic                       wr_en,
    input  logic [awm_pkg::SLOT_W-1:0] wr_addr,
    input  logic [awm_pkg::SYM_W-1:0]  wr_data
);
    import awm_pkg::*;

    logic [SYM_W-1:0] mem [MAX_PATTERN];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/awm_out_fifo.sv
// ----------------------------------------------------------------------------
// awm_out_fifo
// Two-entry result buffer that decouples the matcher from the receiver.
// ----------------------------------------------------------------------------
module awm_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [awm_pkg::POS_W-1:0] push_data,
    output logic [1:0]                count,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [awm_pkg::POS_W-1:0] m_tdata
);
    import awm_pkg::*;

    logic [POS_W-1:0] data0_reg;
    logic [POS_W-1:0] data1_reg;
    logic [1:0]       count_reg;
    logic             pop;

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
        if (pop) begin
            data0_reg <= data1_reg;
            if (push && (count_reg == 2'd1)) begin
                data0_reg <= push_data;
            end
            if (push && (count_reg == 2'd2)) begin
                data1_reg <= push_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                data0_reg <= push_data;
            end else begin
                data1_reg <= push_data;
            end
        end
    end

    assign count    = count_reg;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = data0_reg;

endmodule

// File: rtl/anagram_window_matcher_unit.sv
// ----------------------------------------------------------------------------
// anagram_window_matcher_unit
// Reports every text position whose trailing window is a permutation of the
// learned pattern.
// ----------------------------------------------------------------------------
// Usage: input transactions arrive on the s_ channel. s_tuser carries the
// mode (restart, pattern symbol or text symbol) and s_tdata the symbol byte.
// A restart clears the balance table and the counters. Pattern
// symbols build the pattern, up to 64 of them; text symbols slide the window.
// Each matching window yields one transaction on the m_ channel whose m_tdata
// is the 32-bit start index of that window, wrapping modulo 2^32.
// A text transaction, once a pattern is learned, also passes through the
// ST_LEAVE state, in which s_tready is low, the ring is written and, once
// the window is full, the leaving symbol is applied to the balance memory.
// Restart and pattern transactions, and text while the pattern is empty,
// need no ST_LEAVE state. A match passes through the operation register of
// the balance memory and then the output buffer before it shows on m_tvalid;
// the check for a window that a symbol leaves is made in ST_LEAVE.
// Reset (aresetn low) empties the pattern and window and the result buffer.
// When the receiver stalls, up to two results wait in an output buffer;
// in ST_TAKE, s_tready drops only once no room is left for a new item's result.
// ----------------------------------------------------------------------------
module anagram_window_matcher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] start_index
);
    import awm_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [PLEN_W-1:0] fill_reg, fill_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              started_reg, started_next;
    logic              inflight_reg, inflight_next;
    logic              full_reg, full_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [POS_W-1:0]  idx_reg, idx_next;

    bal_op_t           op;
    bal_res_t          res;
    logic [SYM_W-1:0]  ring_rdata;
    logic              ring_wr;
    logic [1:0]        fifo_count;
    logic              pop;
    logic              credit_ok;
    logic              accept;
    logic              full_now;
    logic [PLEN_W-1:0] slot_inc;
    logic [POS_W-1:0]  start_now;

    assign pop       = m_tvalid && m_tready;
    // Room must remain for a result of any item still in flight plus this one.
    assign credit_ok = (3'(fifo_count) - 3'(pop) + 3'(inflight_reg)) <= 3'd1;
    assign accept    = s_tvalid && s_tready;
    assign full_now  = (fill_reg >= plen_reg);
    assign slot_inc  = PLEN_W'(slot_reg) + PLEN_W'(1);
    assign start_now = pos_reg - POS_W'(plen_reg) + POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_TAKE;
            plen_reg     <= '0;
            fill_reg     <= '0;
            slot_reg     <= '0;
            pos_reg      <= '0;
            started_reg  <= 1'b0;
            inflight_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            plen_reg     <= plen_next;
            fill_reg     <= fill_next;
            slot_reg     <= slot_next;
            pos_reg      <= pos_next;
            started_reg  <= started_next;
            inflight_reg <= inflight_next;
        end
        full_reg  <= full_next;
        wslot_reg <= wslot_next;
        sym_reg   <= sym_next;
        idx_reg   <= idx_next;
    end

    always_comb begin
        state_next    = state_reg;
        plen_next     = plen_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        started_next  = started_reg;
        inflight_next = res.check_done ? 1'b0 : inflight_reg;
        full_next     = full_reg;
        wslot_next    = wslot_reg;
        sym_next      = sym_reg;
        idx_next      = idx_reg;
        op            = '0;
        ring_wr       = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_TAKE: begin
                s_tready = credit_ok;
                if (accept) begin
                    case (mode_t'(s_tuser))
                        MODE_RESTART: begin
                            op.valid     = 1'b1;
                            op.clear     = 1'b1;
                            plen_next    = '0;
                            fill_next    = '0;
                            slot_next    = '0;
                            pos_next     = '0;
                            started_next = 1'b0;
                        end
                        MODE_PATTERN: begin
                            if (!started_reg && (plen_reg < PLEN_W'(MAX_PATTERN))) begin
                                op.valid  = 1'b1;
                                op.inc    = 1'b1;
                                op.addr   = s_tdata;
                                plen_next = plen_reg + PLEN_W'(1);
                            end
                        end
                        MODE_TEXT: begin
                            started_next = 1'b1;
                            pos_next     = pos_reg + POS_W'(1);
                            if (plen_reg != '0) begin
                                // Entering symbol; the check rides on it only
                                // when no symbol leaves the window.
                                op.valid       = 1'b1;
                                op.addr        = s_tdata;
                                op.check       = !full_now &&
                                                 ((fill_reg + PLEN_W'(1)) == plen_reg);
                                op.start_index = start_now;
                                // Only an item that carries a window check can
                                // produce a result.
                                inflight_next  = full_now ||
                                                 ((fill_reg + PLEN_W'(1)) == plen_reg);
                                full_next      = full_now;
                                wslot_next     = slot_reg;
                                sym_next       = s_tdata;
                                idx_next       = start_now;
                                if (!full_now) begin
                                    fill_next = fill_reg + PLEN_W'(1);
                                end
                                slot_next  = (slot_inc >= plen_reg) ? '0 : slot_inc[SLOT_W-1:0];
                                state_next = ST_LEAVE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEAVE: begin
                // The leaving symbol came out of the ring; store the new one.
                ring_wr = 1'b1;
                if (full_reg) begin
                    op.valid       = 1'b1;
                    op.inc         = 1'b1;
                    op.addr        = ring_rdata;
                    op.check       = 1'b1;
                    op.start_index = idx_reg;
                end
                state_next = ST_TAKE;
            end
            default: begin
                state_next = ST_TAKE;
            end
        endcase
    end

    awm_balance_ram u_balance (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_i    (op),
        .res_o   (res)
    );

    awm_ring_ram u_ring (
        .aclk    (aclk),
        .rd_addr (slot_reg),
        .rd_data (ring_rdata),
        .wr_en   (ring_wr),
        .wr_addr (wslot_reg),
        .wr_data (sym_reg)
    );

    awm_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res.hit),
        .push_data (res.start_index),
        .count     (fifo_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
